// ----- src/gaol_pkg.sv -----
// gaol_pkg: token type, operation codes and constants shared by the lookup cells
// and the top level. No dependencies.
package gaol_pkg;

    localparam logic [1:0] OP_WR_ADDR  = 2'd0;
    localparam logic [1:0] OP_WR_ASSOC = 2'd1;
    localparam logic [1:0] OP_FWD      = 2'd2;
    localparam logic [1:0] OP_REV      = 2'd3;

    localparam logic [7:0] NONE_OBJ = 8'hFF;
    localparam logic [7:0] NO_POS   = 8'hFE;

    // one query travelling along a chain of cells
    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [15:0] addr;
        logic [7:0]  obj;
        logic [7:0]  apos;
        logic [7:0]  pos;
        logic [7:0]  fobj;
        logic [15:0] faddr;
        logic        rev_ok;
    } gaol_token_t;

endpackage

// ----- src/gaol_addr_cell.sv -----
// gaol_addr_cell: one address table entry plus one stage of the query chain.
// Depends on gaol_pkg.
module gaol_addr_cell
    import gaol_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [5:0]  group_count,
    input  gaol_token_t tok_in,
    output gaol_token_t tok_out
);

    logic [15:0] entry_reg, entry_next;
    gaol_token_t tok_reg, tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                OP_WR_ADDR:
                begin
                    if ({2'b00, tok_in.idx} == 8'(INDEX))
                        entry_next = tok_in.addr;
                end
                OP_FWD:
                begin
                    // later cells override, so the last match wins
                    if (INDEX >= 1 && 8'(INDEX) <= {2'b00, group_count}
                        && entry_reg == tok_in.addr)
                        tok_next.pos = 8'(INDEX);
                end
                OP_REV:
                begin
                    if (tok_in.rev_ok && tok_in.pos == 8'(INDEX))
                        tok_next.faddr = entry_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/gaol_assoc_cell.sv -----
// gaol_assoc_cell: one association entry (position, object) plus one chain stage.
// Depends on gaol_pkg.
module gaol_assoc_cell
    import gaol_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  assoc_count,
    input  gaol_token_t tok_in,
    output gaol_token_t tok_out
);

    logic [15:0] entry_reg, entry_next;
    gaol_token_t tok_reg, tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                OP_WR_ASSOC:
                begin
                    if ({2'b00, tok_in.idx} == 8'(INDEX))
                        entry_next = {tok_in.apos, tok_in.obj};
                end
                OP_FWD:
                begin
                    // first usable entry only
                    if (tok_in.pos != NONE_OBJ && tok_in.fobj == NONE_OBJ
                        && 8'(INDEX) < {1'b0, assoc_count}
                        && entry_reg[15:8] == tok_in.pos
                        && entry_reg[7:0] != NONE_OBJ)
                        tok_next.fobj = entry_reg[7:0];
                end
                OP_REV:
                begin
                    if (tok_in.obj == 8'(INDEX) && entry_reg[7:0] == tok_in.obj
                        && entry_reg[15:8] != NO_POS)
                    begin
                        tok_next.rev_ok = 1'b1;
                        tok_next.pos    = entry_reg[15:8];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/group_address_object_lookup.sv -----
// group_address_object_lookup: top level, sequencer and the two cell chains.
// Depends on gaol_pkg, gaol_addr_cell and gaol_assoc_cell.
//
// channel  direction  handshake            word
// in       to block   in_valid / in_stall  opcode, entry_index, group_addr,
//                                          object_number, assoc_position
// out      from block out_valid / out_stall hit, found_object, found_addr,
//                                          found_position
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word at a time; its token runs through the address chain and/or the
// association chain, one cell a cycle: writes use one chain, forward lookups
// the address chain then the association chain, reverse lookups the
// association chain then the address chain
// reset clears both tables and both counts at once
// the result waits in the output register; the next word is taken meanwhile
module group_address_object_lookup
    import gaol_pkg::*;
#(
    parameter int ADDR_ENTRIES  = 64,
    parameter int ASSOC_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [5:0]  entry_index,
    input  logic [15:0] group_addr,
    input  logic [7:0]  object_number,
    input  logic [7:0]  assoc_position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [7:0]  found_object,
    output logic [15:0] found_addr,
    output logic [7:0]  found_position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam logic [1:0] CFG_GROUP_COUNT = 2'd0;
    localparam logic [1:0] CFG_ASSOC_COUNT = 2'd1;

    typedef enum logic [1:0] { IDLE, RUN, FINISH } state_t;

    state_t      state_reg;
    gaol_token_t token_reg;
    logic        addr_go_reg, assoc_go_reg;
    logic [5:0]  group_count_reg;
    logic [6:0]  assoc_count_reg;
    logic        out_valid_reg, hit_reg;
    logic [7:0]  fobj_reg, fpos_reg;
    logic [15:0] faddr_reg;

    gaol_token_t addr_tok  [ADDR_ENTRIES+1];
    gaol_token_t assoc_tok [ASSOC_ENTRIES+1];

    logic        res_hit;
    logic [7:0]  res_fobj, res_fpos;
    logic [15:0] res_faddr;
    logic        rev_hit;

    always_comb
    begin
        addr_tok[0]      = token_reg;
        addr_tok[0].vld  = addr_go_reg;
        assoc_tok[0]     = token_reg;
        assoc_tok[0].vld = assoc_go_reg;
    end

    for (genvar g = 0; g < ADDR_ENTRIES; g++)
    begin : g_addr
        gaol_addr_cell #(.INDEX(g)) u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .group_count (group_count_reg),
            .tok_in      (addr_tok[g]),
            .tok_out     (addr_tok[g+1])
        );
    end

    for (genvar g = 0; g < ASSOC_ENTRIES; g++)
    begin : g_assoc
        gaol_assoc_cell #(.INDEX(g)) u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .assoc_count (assoc_count_reg),
            .tok_in      (assoc_tok[g]),
            .tok_out     (assoc_tok[g+1])
        );
    end

    // result from the finished token
    always_comb
    begin
        rev_hit   = token_reg.rev_ok && (token_reg.pos < 8'(ADDR_ENTRIES));
        res_hit   = 1'b0;
        res_fobj  = NONE_OBJ;
        res_faddr = '0;
        res_fpos  = NONE_OBJ;
        unique case (token_reg.op)
            OP_WR_ADDR:  res_hit = {2'b00, token_reg.idx} < 8'(ADDR_ENTRIES);
            OP_WR_ASSOC: res_hit = {2'b00, token_reg.idx} < 8'(ASSOC_ENTRIES);
            OP_FWD:
            begin
                res_fpos = token_reg.pos;
                res_fobj = token_reg.fobj;
                res_hit  = token_reg.fobj != NONE_OBJ;
            end
            OP_REV:
            begin
                res_hit = rev_hit;
                if (rev_hit)
                begin
                    res_faddr = token_reg.faddr;
                    res_fpos  = token_reg.pos;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            token_reg       <= '0;
            addr_go_reg     <= 1'b0;
            assoc_go_reg    <= 1'b0;
            group_count_reg <= '0;
            assoc_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            fobj_reg        <= '0;
            faddr_reg       <= '0;
            fpos_reg        <= '0;
        end
        else
        begin
            addr_go_reg  <= 1'b0;
            assoc_go_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GROUP_COUNT: group_count_reg <= cfg_data[5:0];
                    CFG_ASSOC_COUNT: assoc_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        token_reg.vld    <= 1'b1;
                        token_reg.op     <= opcode;
                        token_reg.idx    <= entry_index;
                        token_reg.addr   <= group_addr;
                        token_reg.obj    <= object_number;
                        token_reg.apos   <= assoc_position;
                        token_reg.pos    <= NONE_OBJ;
                        token_reg.fobj   <= NONE_OBJ;
                        token_reg.faddr  <= '0;
                        token_reg.rev_ok <= 1'b0;
                        if (opcode == OP_WR_ADDR || opcode == OP_FWD)
                            addr_go_reg <= 1'b1;
                        else
                            assoc_go_reg <= 1'b1;
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    if (addr_tok[ADDR_ENTRIES].vld)
                    begin
                        token_reg <= addr_tok[ADDR_ENTRIES];
                        if (addr_tok[ADDR_ENTRIES].op == OP_FWD)
                            assoc_go_reg <= 1'b1;
                        else
                            state_reg <= FINISH;
                    end
                    else if (assoc_tok[ASSOC_ENTRIES].vld)
                    begin
                        token_reg <= assoc_tok[ASSOC_ENTRIES];
                        if (assoc_tok[ASSOC_ENTRIES].op == OP_REV)
                            addr_go_reg <= 1'b1;
                        else
                            state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= res_hit;
                        fobj_reg      <= res_fobj;
                        faddr_reg     <= res_faddr;
                        fpos_reg      <= res_fpos;
                        state_reg     <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign in_stall       = (state_reg != IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign found_object   = fobj_reg;
    assign found_addr     = faddr_reg;
    assign found_position = fpos_reg;

endmodule
